// ----- hw/rtl/length_prefixed_frame_decoder_assert.svh -----
// Assertion macros used by the checker file of the frame decoder.
`ifndef LENGTH_PREFIXED_FRAME_DECODER_ASSERT_SVH
`define LENGTH_PREFIXED_FRAME_DECODER_ASSERT_SVH

// Same-cycle implication, switched off while reset is held.
`define LPFD_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, switched off while reset is held.
`define LPFD_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

// Checks what must hold in the cycle after reset has been sampled low.
`define LPFD_ASSERT_RESET(label, clk, rst_n, cons, msg) \
    label: assert property (@(posedge clk) (!rst_n) |=> (cons)) \
        else $error(msg);

`endif

// ----- hw/rtl/lpfd_pkg.sv -----
package lpfd_pkg;

    localparam int LEN_BITS       = 24;
    localparam int WORD_BITS      = 32;
    localparam int FIXED_OVERHEAD = 26;
    localparam int CFG_BITS       = 24;
    localparam int CFG_IDX_BITS   = 2;
    localparam int WORD_BYTES     = 4;

    // Largest frame length that the length counters can hold.
    localparam logic [WORD_BITS-1:0] LEN_MAX = WORD_BITS'((64'd1 << LEN_BITS) - 64'd1);

    localparam logic [7:0]          START_RESET   = 8'd2;
    localparam logic [7:0]          END_RESET     = 8'd3;
    localparam logic [CFG_BITS-1:0] MAX_LEN_RESET = CFG_BITS'(65535);

    typedef enum logic [CFG_IDX_BITS-1:0] {
        REG_START   = 2'd0,
        REG_END     = 2'd1,
        REG_MAX_LEN = 2'd2
    } t_reg_idx;

    typedef enum logic [3:0] {
        PH_HUNT    = 4'd0,
        PH_FLEN    = 4'd1,
        PH_IDLEN   = 4'd2,
        PH_ID      = 4'd3,
        PH_MLEN    = 4'd4,
        PH_METHOD  = 4'd5,
        PH_ECODE   = 4'd6,
        PH_ILEN    = 4'd7,
        PH_INFO    = 4'd8,
        PH_PAYLOAD = 4'd9,
        PH_CSUM    = 4'd10,
        PH_END     = 4'd11
    } t_phase;

    typedef enum logic [2:0] {
        KIND_ID      = 3'd0,
        KIND_METHOD  = 3'd1,
        KIND_CODE    = 3'd2,
        KIND_INFO    = 3'd3,
        KIND_PAYLOAD = 3'd4,
        KIND_OK      = 3'd5,
        KIND_ERR     = 3'd6
    } t_kind;

    typedef enum logic [2:0] {
        CAUSE_NONE        = 3'd0,
        CAUSE_ID_OVER     = 3'd1,
        CAUSE_METHOD_OVER = 3'd2,
        CAUSE_INFO_OVER   = 3'd3,
        CAUSE_BAD_END     = 3'd4,
        CAUSE_BAD_LEN     = 3'd5
    } t_cause;

    typedef struct packed {
        logic [7:0]          start_delim;
        logic [7:0]          end_delim;
        logic [CFG_BITS-1:0] max_len;
    } t_cfg;

    typedef struct packed {
        logic                        valid;
        t_kind                       kind;
        logic [7:0]                  field_byte;
        logic signed [WORD_BITS-1:0] error_code;
        t_cause                      cause;
        logic                        last;
    } t_result;

endpackage

// ----- hw/rtl/length_prefixed_frame_decoder.sv -----
// Channel   Direction  Handshake          Payload
// input     in         i_valid / o_stall  i_data_byte
// result    out        o_valid / i_stall  o_kind, o_field_byte, o_error_code,
//                                         o_error_cause, o_frame_last
// config    in         i_cfg_we           i_cfg_idx, i_cfg_data
//
// One byte a cycle is sustained while the result side does not stall: a byte waits in the
// input register, where the frame state machine decodes it, and its result, if any, is then
// loaded into the result register.
// Reset is synchronous and active low; it returns the parser to hunting and loads the
// register defaults. A stalled result holds the held byte in the input register, and
// the input stalls only once that register is also full.
module length_prefixed_frame_decoder (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_valid,
    output logic                                o_stall,
    input  logic [7:0]                          i_data_byte,
    output logic                                o_valid,
    input  logic                                i_stall,
    output logic [2:0]                          o_kind,
    output logic [7:0]                          o_field_byte,
    output logic signed [lpfd_pkg::WORD_BITS-1:0] o_error_code,
    output logic [2:0]                          o_error_cause,
    output logic                                o_frame_last,
    input  logic                                i_cfg_we,
    input  logic [lpfd_pkg::CFG_IDX_BITS-1:0]   i_cfg_idx,
    input  logic [lpfd_pkg::CFG_BITS-1:0]       i_cfg_data
);

    lpfd_pkg::t_cfg    r_cfg;
    lpfd_pkg::t_result w_result;
    lpfd_pkg::t_result r_out;

    logic       r_in_valid;
    logic [7:0] r_in_byte;
    logic       w_out_free;
    logic       w_step;
    logic       w_accept;

    assign w_out_free = !r_out.valid || !i_stall;
    assign w_step     = r_in_valid && w_out_free;
    assign o_stall    = r_in_valid && !w_out_free;
    assign w_accept   = i_valid && !o_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.start_delim <= lpfd_pkg::START_RESET;
            r_cfg.end_delim   <= lpfd_pkg::END_RESET;
            r_cfg.max_len     <= lpfd_pkg::MAX_LEN_RESET;
        end else if (i_cfg_we) begin
            case (lpfd_pkg::t_reg_idx'(i_cfg_idx))
                lpfd_pkg::REG_START:   r_cfg.start_delim <= i_cfg_data[7:0];
                lpfd_pkg::REG_END:     r_cfg.end_delim   <= i_cfg_data[7:0];
                lpfd_pkg::REG_MAX_LEN: r_cfg.max_len     <= i_cfg_data;
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else begin
            r_in_valid <= w_accept || (r_in_valid && !w_step);
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_in_byte <= i_data_byte;
        end
    end

    lpfd_parser u_parser (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_step   (w_step),
        .i_byte   (r_in_byte),
        .i_cfg    (r_cfg),
        .o_result (w_result)
    );

    // The result register loads whenever the downstream side can take a transfer.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out.valid <= 1'b0;
        end else if (w_out_free) begin
            r_out.valid <= w_step && w_result.valid;
        end
        if (w_step) begin
            r_out.kind       <= w_result.kind;
            r_out.field_byte <= w_result.field_byte;
            r_out.error_code <= w_result.error_code;
            r_out.cause      <= w_result.cause;
            r_out.last       <= w_result.last;
        end
    end

    assign o_valid       = r_out.valid;
    assign o_kind        = r_out.kind;
    assign o_field_byte  = r_out.field_byte;
    assign o_error_code  = r_out.error_code;
    assign o_error_cause = r_out.cause;
    assign o_frame_last  = r_out.last;

endmodule

// ----- hw/rtl/lpfd_parser.sv -----
module lpfd_parser (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_step,
    input  logic [7:0]        i_byte,
    input  lpfd_pkg::t_cfg    i_cfg,
    output lpfd_pkg::t_result o_result
);

    lpfd_pkg::t_phase                r_phase, n_phase;
    logic [lpfd_pkg::LEN_BITS-1:0]   r_count, n_count;
    logic [lpfd_pkg::LEN_BITS-1:0]   r_remain, n_remain;
    logic [lpfd_pkg::WORD_BITS-9:0]  r_acc, n_acc;

    logic [lpfd_pkg::WORD_BITS-1:0]  w_word;
    logic [lpfd_pkg::LEN_BITS-1:0]   w_word_len;
    logic [lpfd_pkg::LEN_BITS-1:0]   w_pay_len;
    logic                            w_last_byte;
    logic                            w_len_bad;
    logic                            w_over;

    // The word in progress with this byte shifted in, big-endian.
    assign w_word      = {r_acc, i_byte};
    assign w_word_len  = w_word[lpfd_pkg::LEN_BITS-1:0];
    assign w_last_byte = (r_count == lpfd_pkg::LEN_BITS'(1));
    assign w_len_bad   = (w_word < lpfd_pkg::WORD_BITS'(lpfd_pkg::FIXED_OVERHEAD))
                      || (w_word > lpfd_pkg::WORD_BITS'(i_cfg.max_len))
                      || (w_word > lpfd_pkg::LEN_MAX);
    // r_remain holds what the frame length still leaves for the fields to come.
    assign w_over      = (w_word > lpfd_pkg::WORD_BITS'(r_remain));
    assign w_pay_len   = r_remain - w_word_len;

    always_comb begin
        n_phase  = r_phase;
        n_count  = r_count;
        n_remain = r_remain;
        n_acc    = r_acc;
        case (r_phase)
            lpfd_pkg::PH_ID, lpfd_pkg::PH_METHOD, lpfd_pkg::PH_INFO,
            lpfd_pkg::PH_PAYLOAD: begin
                n_count = r_count - lpfd_pkg::LEN_BITS'(1);
                if (w_last_byte) begin
                    n_count = lpfd_pkg::LEN_BITS'(lpfd_pkg::WORD_BYTES);
                    n_acc   = '0;
                    case (r_phase)
                        lpfd_pkg::PH_ID:     n_phase = lpfd_pkg::PH_MLEN;
                        lpfd_pkg::PH_METHOD: n_phase = lpfd_pkg::PH_ECODE;
                        lpfd_pkg::PH_INFO: begin
                            if (r_remain != '0) begin
                                n_phase = lpfd_pkg::PH_PAYLOAD;
                                n_count = r_remain;
                            end else begin
                                n_phase = lpfd_pkg::PH_CSUM;
                            end
                        end
                        default:             n_phase = lpfd_pkg::PH_CSUM;
                    endcase
                end
            end
            lpfd_pkg::PH_CSUM: begin
                n_count = r_count - lpfd_pkg::LEN_BITS'(1);
                if (w_last_byte) begin
                    n_phase = lpfd_pkg::PH_END;
                end
            end
            lpfd_pkg::PH_END: begin
                n_phase = lpfd_pkg::PH_HUNT;
                n_count = '0;
            end
            lpfd_pkg::PH_FLEN, lpfd_pkg::PH_IDLEN, lpfd_pkg::PH_MLEN,
            lpfd_pkg::PH_ECODE, lpfd_pkg::PH_ILEN: begin
                n_acc   = w_word[lpfd_pkg::WORD_BITS-9:0];
                n_count = r_count - lpfd_pkg::LEN_BITS'(1);
                if (w_last_byte) begin
                    n_acc   = '0;
                    n_count = lpfd_pkg::LEN_BITS'(lpfd_pkg::WORD_BYTES);
                    case (r_phase)
                        lpfd_pkg::PH_FLEN: begin
                            if (w_len_bad) begin
                                n_phase = lpfd_pkg::PH_HUNT;
                                n_count = '0;
                            end else begin
                                n_phase  = lpfd_pkg::PH_IDLEN;
                                n_remain = w_word_len
                                         - lpfd_pkg::LEN_BITS'(lpfd_pkg::FIXED_OVERHEAD);
                            end
                        end
                        lpfd_pkg::PH_IDLEN, lpfd_pkg::PH_MLEN: begin
                            if (w_over) begin
                                n_phase = lpfd_pkg::PH_HUNT;
                                n_count = '0;
                            end else begin
                                n_remain = w_pay_len;
                                n_phase  = (r_phase == lpfd_pkg::PH_IDLEN)
                                         ? lpfd_pkg::PH_MLEN : lpfd_pkg::PH_ECODE;
                                if (w_word_len != '0) begin
                                    n_phase = (r_phase == lpfd_pkg::PH_IDLEN)
                                            ? lpfd_pkg::PH_ID : lpfd_pkg::PH_METHOD;
                                    n_count = w_word_len;
                                end
                            end
                        end
                        lpfd_pkg::PH_ECODE: n_phase = lpfd_pkg::PH_ILEN;
                        default: begin
                            if (w_over) begin
                                n_phase = lpfd_pkg::PH_HUNT;
                                n_count = '0;
                            end else begin
                                n_remain = w_pay_len;
                                if (w_word_len != '0) begin
                                    n_phase = lpfd_pkg::PH_INFO;
                                    n_count = w_word_len;
                                end else if (w_pay_len != '0) begin
                                    n_phase = lpfd_pkg::PH_PAYLOAD;
                                    n_count = w_pay_len;
                                end else begin
                                    n_phase = lpfd_pkg::PH_CSUM;
                                end
                            end
                        end
                    endcase
                end
            end
            default: begin
                n_count = '0;
                if (i_byte == i_cfg.start_delim) begin
                    n_phase  = lpfd_pkg::PH_FLEN;
                    n_count  = lpfd_pkg::LEN_BITS'(lpfd_pkg::WORD_BYTES);
                    n_acc    = '0;
                    n_remain = '0;
                end
            end
        endcase
    end

    always_comb begin
        o_result            = '0;
        o_result.kind       = lpfd_pkg::KIND_ID;
        o_result.cause      = lpfd_pkg::CAUSE_NONE;
        case (r_phase)
            lpfd_pkg::PH_ID: begin
                o_result.valid      = 1'b1;
                o_result.field_byte = i_byte;
            end
            lpfd_pkg::PH_METHOD: begin
                o_result.valid      = 1'b1;
                o_result.kind       = lpfd_pkg::KIND_METHOD;
                o_result.field_byte = i_byte;
            end
            lpfd_pkg::PH_INFO: begin
                o_result.valid      = 1'b1;
                o_result.kind       = lpfd_pkg::KIND_INFO;
                o_result.field_byte = i_byte;
            end
            lpfd_pkg::PH_PAYLOAD: begin
                o_result.valid      = 1'b1;
                o_result.kind       = lpfd_pkg::KIND_PAYLOAD;
                o_result.field_byte = i_byte;
            end
            lpfd_pkg::PH_END: begin
                o_result.valid = 1'b1;
                o_result.last  = 1'b1;
                if (i_byte == i_cfg.end_delim) begin
                    o_result.kind = lpfd_pkg::KIND_OK;
                end else begin
                    o_result.kind  = lpfd_pkg::KIND_ERR;
                    o_result.cause = lpfd_pkg::CAUSE_BAD_END;
                end
            end
            lpfd_pkg::PH_ECODE: begin
                if (w_last_byte) begin
                    o_result.valid      = 1'b1;
                    o_result.kind       = lpfd_pkg::KIND_CODE;
                    o_result.error_code = w_word;
                end
            end
            lpfd_pkg::PH_FLEN, lpfd_pkg::PH_IDLEN, lpfd_pkg::PH_MLEN,
            lpfd_pkg::PH_ILEN: begin
                o_result.kind = lpfd_pkg::KIND_ERR;
                o_result.last = 1'b1;
                case (r_phase)
                    lpfd_pkg::PH_FLEN: begin
                        o_result.valid = w_last_byte && w_len_bad;
                        o_result.cause = lpfd_pkg::CAUSE_BAD_LEN;
                    end
                    lpfd_pkg::PH_IDLEN: begin
                        o_result.valid = w_last_byte && w_over;
                        o_result.cause = lpfd_pkg::CAUSE_ID_OVER;
                    end
                    lpfd_pkg::PH_MLEN: begin
                        o_result.valid = w_last_byte && w_over;
                        o_result.cause = lpfd_pkg::CAUSE_METHOD_OVER;
                    end
                    default: begin
                        o_result.valid = w_last_byte && w_over;
                        o_result.cause = lpfd_pkg::CAUSE_INFO_OVER;
                    end
                endcase
            end
            default: begin
                o_result.valid = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase  <= lpfd_pkg::PH_HUNT;
            r_count  <= '0;
            r_remain <= '0;
            r_acc    <= '0;
        end else if (i_step) begin
            r_phase  <= n_phase;
            r_count  <= n_count;
            r_remain <= n_remain;
            r_acc    <= n_acc;
        end
    end

endmodule

// ----- hw/rtl/lpfd_checker.sv -----
`include "length_prefixed_frame_decoder_assert.svh"

module lpfd_checker (
    input logic                                i_clk,
    input logic                                i_rst_n,
    input logic                                o_valid,
    input logic                                i_stall,
    input logic [2:0]                          o_kind,
    input logic signed [lpfd_pkg::WORD_BITS-1:0] o_error_code,
    input logic [2:0]                          o_error_cause,
    input logic                                o_frame_last
);

    `LPFD_ASSERT_RESET(a_reset_clears_valid, i_clk, i_rst_n, !o_valid, "result valid after reset")

    `LPFD_ASSERT_NEXT(a_stalled_result_holds, i_clk, i_rst_n, o_valid && i_stall, o_valid && $stable(o_kind), "stalled result changed")

    `LPFD_ASSERT_NOW(a_last_on_close_only, i_clk, i_rst_n, o_valid, o_frame_last == ((o_kind == lpfd_pkg::KIND_OK) || (o_kind == lpfd_pkg::KIND_ERR)), "frame_last disagrees with kind")

    `LPFD_ASSERT_NOW(a_cause_on_error_only, i_clk, i_rst_n, o_valid && (o_kind != lpfd_pkg::KIND_ERR), o_error_cause == lpfd_pkg::CAUSE_NONE, "cause set on a non-error result")

    `LPFD_ASSERT_NOW(a_code_on_code_only, i_clk, i_rst_n, o_valid && (o_kind != lpfd_pkg::KIND_CODE), o_error_code == '0, "error code set on another kind")

endmodule

bind length_prefixed_frame_decoder lpfd_checker u_lpfd_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .o_valid       (o_valid),
    .i_stall       (i_stall),
    .o_kind        (o_kind),
    .o_error_code  (o_error_code),
    .o_error_cause (o_error_cause),
    .o_frame_last  (o_frame_last)
);
